// File: hdl/ssm_pkg.sv
package ssm_pkg;

   localparam int CAPACITY   = 256;
   localparam int VALUE_BITS = 32;
   localparam int KEY_BITS   = 8;
   localparam int POS_BITS   = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);

   localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

   typedef enum logic [1:0] {
      ACT_SET    = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  key;
      logic [31:0] data_value;
      logic [7:0]  position;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [31:0] result_value;
      logic [7:0]  result_key;
      logic [8:0]  entry_count;
      status_type  status;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;        // request transfer this cycle
      logic finish_now;    // set or clear: load the response at once
      logic fetch_dense;   // sparse position is out, read dense at it
      logic finish_fetch;  // dense data is out, load the response
   } cmd_type;

endpackage

// File: hdl/sparse_set_map.sv
// From request transfer to response valid: set and clear load the response
// register directly; read entry passes through ST_DENSE; lookup passes through
// ST_SPARSE and ST_DENSE (sparse read, then dependent dense read).
// One item at a time: the next request transfers the cycle after the response transfers.
// Synchronous reset zeroes the entry count and the sparse valid bits;
// key and value memories are not cleared.
module sparse_set_map (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssm_pkg::rsp_type rsp_data
);

   ssm_pkg::cmd_type cmd;

   ssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_action(req_data.action),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ssm_datapath u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .req_data(req_data),
      .rsp_data(rsp_data)
   );

endmodule

// File: hdl/ssm_ram.sv
module ssm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ssm_ctrl.sv
module ssm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ssm_pkg::action_type req_action,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ssm_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SPARSE = 4'b0010,
      ST_DENSE  = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in         = state_ff;
      req_ready        = 1'b0;
      rsp_valid        = 1'b0;
      cmd.accept       = 1'b0;
      cmd.finish_now   = 1'b0;
      cmd.fetch_dense  = 1'b0;
      cmd.finish_fetch = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_action)
                  ssm_pkg::ACT_LOOKUP: begin
                     state_in = ST_SPARSE;
                  end
                  ssm_pkg::ACT_READ: begin
                     state_in = ST_DENSE;
                  end
                  default: begin
                     cmd.finish_now = 1'b1;
                     state_in       = ST_RESP;
                  end
               endcase
            end
         end
         ST_SPARSE: begin
            cmd.fetch_dense = 1'b1;
            state_in        = ST_DENSE;
         end
         ST_DENSE: begin
            cmd.finish_fetch = 1'b1;
            state_in         = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/ssm_datapath.sv
module ssm_datapath (
   input  logic             clock,
   input  logic             reset,
   input  ssm_pkg::cmd_type cmd,
   input  ssm_pkg::req_type req_data,
   output ssm_pkg::rsp_type rsp_data
);

   ssm_pkg::req_type req_ff;
   ssm_pkg::rsp_type rsp_ff;
   ssm_pkg::rsp_type rsp_in;

   logic [ssm_pkg::CNT_BITS-1:0] count_ff;
   logic [ssm_pkg::CNT_BITS-1:0] count_in;
   logic [ssm_pkg::CAPACITY-1:0] sparse_vld_ff;
   logic [ssm_pkg::CAPACITY-1:0] sparse_vld_in;
   logic                         sparse_hit_ff;
   logic                         range_ok_ff;
   logic                         range_ok_in;

   logic                           set_ok;
   logic                           set_wr;
   logic [ssm_pkg::POS_BITS-1:0]   key_idx;
   logic [ssm_pkg::POS_BITS-1:0]   wr_pos;
   logic [ssm_pkg::POS_BITS-1:0]   sparse_rd;
   logic [ssm_pkg::POS_BITS-1:0]   sparse_pos;
   logic [ssm_pkg::POS_BITS-1:0]   dense_addr;
   logic [ssm_pkg::KEY_BITS-1:0]   dense_key;
   logic [ssm_pkg::VALUE_BITS-1:0] dense_value;
   logic                           key_match;
   logic                           pos_ok;

   assign key_idx = req_data.key[ssm_pkg::POS_BITS-1:0];
   assign wr_pos  = count_ff[ssm_pkg::POS_BITS-1:0];
   assign set_ok  = (count_ff < ssm_pkg::CAP_CNT) && (32'(req_data.key) < ssm_pkg::CAPACITY);
   assign set_wr  = cmd.finish_now && (req_data.action == ssm_pkg::ACT_SET) && set_ok;

   // Never-written sparse slots read as position zero
   assign sparse_pos = sparse_hit_ff ? sparse_rd : '0;
   assign dense_addr = cmd.fetch_dense ? sparse_pos : req_data.position[ssm_pkg::POS_BITS-1:0];

   ssm_ram #(
      .WIDTH(ssm_pkg::POS_BITS),
      .DEPTH(ssm_pkg::CAPACITY)
   ) u_sparse (
      .clock  (clock),
      .wr_en  (set_wr),
      .wr_addr(key_idx),
      .wr_data(wr_pos),
      .rd_addr(key_idx),
      .rd_data(sparse_rd)
   );

   ssm_ram #(
      .WIDTH(ssm_pkg::KEY_BITS),
      .DEPTH(ssm_pkg::CAPACITY)
   ) u_dense (
      .clock  (clock),
      .wr_en  (set_wr),
      .wr_addr(wr_pos),
      .wr_data(req_data.key),
      .rd_addr(dense_addr),
      .rd_data(dense_key)
   );

   ssm_ram #(
      .WIDTH(ssm_pkg::VALUE_BITS),
      .DEPTH(ssm_pkg::CAPACITY)
   ) u_value (
      .clock  (clock),
      .wr_en  (set_wr),
      .wr_addr(wr_pos),
      .wr_data(req_data.data_value[ssm_pkg::VALUE_BITS-1:0]),
      .rd_addr(dense_addr),
      .rd_data(dense_value)
   );

   assign key_match = (dense_key == req_ff.key);
   assign pos_ok    = (ssm_pkg::CNT_BITS'(req_ff.position) < count_ff)
                      && (32'(req_ff.position) < ssm_pkg::CAPACITY);

   always_comb begin
      count_in      = count_ff;
      sparse_vld_in = sparse_vld_ff;
      range_ok_in   = range_ok_ff;
      rsp_in        = rsp_ff;

      if (cmd.fetch_dense) begin
         range_ok_in = (ssm_pkg::CNT_BITS'(sparse_pos) < count_ff)
                       && (32'(req_ff.key) < ssm_pkg::CAPACITY);
      end

      if (cmd.finish_now) begin
         rsp_in.found        = 1'b0;
         rsp_in.result_value = '0;
         rsp_in.result_key   = '0;
         rsp_in.status       = ssm_pkg::STS_OK;
         if (req_data.action == ssm_pkg::ACT_CLEAR) begin
            count_in = '0;
         end else if (set_ok) begin
            count_in               = count_ff + 1'b1;
            sparse_vld_in[key_idx] = 1'b1;
         end else begin
            rsp_in.status = ssm_pkg::STS_FULL;
         end
         rsp_in.entry_count = 9'(count_in);
      end

      if (cmd.finish_fetch) begin
         rsp_in.found        = 1'b0;
         rsp_in.result_value = '0;
         rsp_in.result_key   = '0;
         rsp_in.status       = ssm_pkg::STS_OK;
         rsp_in.entry_count  = 9'(count_ff);
         if (req_ff.action == ssm_pkg::ACT_LOOKUP) begin
            if (range_ok_ff && key_match) begin
               rsp_in.found        = 1'b1;
               rsp_in.result_value = 32'(dense_value);
            end
         end else if (pos_ok) begin
            rsp_in.result_value = 32'(dense_value);
            rsp_in.result_key   = 8'(dense_key);
         end else begin
            rsp_in.status = ssm_pkg::STS_RANGE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         sparse_vld_ff <= '0;
      end else begin
         count_ff      <= count_in;
         sparse_vld_ff <= sparse_vld_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      sparse_hit_ff <= sparse_vld_ff[key_idx];
      range_ok_ff   <= range_ok_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule
